>>> rtl/hrll_pkg.sv
`default_nettype none
package hrll_pkg;

    // Input commands carried in tuser
    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_EOL  = 2'd1;
    localparam logic [1:0] CMD_SOF  = 2'd2;

    // Line status codes
    localparam logic [1:0] LS_OK       = 2'd0;
    localparam logic [1:0] LS_BAD_DATA = 2'd1;
    localparam logic [1:0] LS_BAD_CMNT = 2'd2;

    // Fixed record layout
    localparam logic [5:0] ADDR_COLUMN = 6'd2;
    localparam logic [5:0] DATA_COLUMN = 6'd7;
    localparam logic [5:0] BAR_COLUMN  = 6'd28;
    localparam logic [5:0] COLUMN_MAX  = 6'd63;
    localparam int         MEM_SIZE    = 4096;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_STATUS
    } state_t;

    // Hex digit value in bits 3:0; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hrll_ram.sv
`default_nettype none
module hrll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/hex_record_line_loader.sv
`default_nettype none
// Loader for text object files of the ".yo" kind. Each input request carries
// one command in tuser (character, end of line, start of file) and the
// character in tdata. Characters are checked against the record layout as
// they arrive, one per cycle, and the hex byte pairs of a data record are
// parked in a small byte-buffer RAM. At end of line a valid data record
// drains its bytes as memory-write results (tuser = 1), then one status
// result with tlast set; a bad line gives only the status result and halts
// loading until the next start-of-file command. Timing: characters and
// start-of-file are taken every cycle; an end-of-line occupies the block
// while each buffered byte passes through a read state, set by the single
// registered read port of the byte buffer, and an emit state, and then the
// status is loaded; any stall on the output side adds to this. Input is
// not taken while a line's results are being drained, but a finished result
// sitting in the output register never blocks incoming characters.
module hex_record_line_loader #(
    parameter int MAX_BYTES = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // addr[11:0], data[19:12],
                                             // line_status[21:20],
                                             // line_number[37:22], zero pad
    output logic             m_axis_tuser,   // write_en
    output logic             m_axis_tlast    // last
);

    import hrll_pkg::*;

    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int PC_W  = $clog2(MAX_BYTES + 2);
    localparam logic [PC_W-1:0] PC_MAX = PC_W'(MAX_BYTES);

    // Line parsing state
    logic [5:0]      column_reg, column_next;
    logic            is_data_reg, is_data_next;
    logic [11:0]     accum_reg, accum_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [4:0]      half_reg, half_next;
    logic            run_open_reg, run_open_next;
    logic            fault_reg, fault_next;
    // File state
    logic            loaded_reg, loaded_next;
    logic [11:0]     last_addr_reg, last_addr_next;
    logic [15:0]     line_count_reg, line_count_next;
    logic            halted_reg, halted_next;
    // Drain state
    state_t          state_reg, state_next;
    logic [11:0]     base_reg, base_next;
    logic [PC_W-1:0] cnt_reg, cnt_next;
    logic [PC_W-1:0] idx_reg, idx_next;
    logic [15:0]     ln_reg, ln_next;
    logic [1:0]      status_reg, status_next;
    // Output register
    logic            out_valid_reg, out_valid_next;
    logic            out_we_reg, out_we_next;
    logic [11:0]     out_addr_reg, out_addr_next;
    logic [7:0]      out_data_reg, out_data_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic [15:0]     out_ln_reg, out_ln_next;
    logic            out_last_reg, out_last_next;

    // Byte buffer port signals
    logic             buf_wr_en;
    logic [IDX_W-1:0] buf_wr_addr;
    logic [7:0]       buf_wr_data;
    logic             buf_rd_en;
    logic [7:0]       buf_rd_data;

    logic       in_fire;
    logic       out_free;
    logic [4:0] hv;
    logic       is_hex;
    logic       eol_data;
    logic       eol_bad;
    logic [13:0] end_addr;

    hrll_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES),
        .AW    (IDX_W)
    ) u_byte_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (buf_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign hv     = hex_of(s_axis_tdata);
    assign is_hex = !hv[4];

    assign eol_data = is_data_reg && (column_reg >= ADDR_COLUMN);
    assign end_addr = {2'b00, accum_reg} + 14'(pc_reg);

    always_comb
    begin
        eol_bad = fault_reg || (column_reg <= BAR_COLUMN);
        if (eol_data && !eol_bad)
        begin
            if (loaded_reg && (accum_reg <= last_addr_reg))
            begin
                eol_bad = 1'b1;
            end
            if ((pc_reg > PC_MAX) || (end_addr > 14'(MEM_SIZE)))
            begin
                eol_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        column_next     = column_reg;
        is_data_next    = is_data_reg;
        accum_next      = accum_reg;
        pc_next         = pc_reg;
        half_next       = half_reg;
        run_open_next   = run_open_reg;
        fault_next      = fault_reg;
        loaded_next     = loaded_reg;
        last_addr_next  = last_addr_reg;
        line_count_next = line_count_reg;
        halted_next     = halted_reg;
        state_next      = state_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ln_next         = ln_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_we_next     = out_we_reg;
        out_addr_next   = out_addr_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_ln_next     = out_ln_reg;
        out_last_next   = out_last_reg;
        buf_wr_en       = 1'b0;
        buf_wr_addr     = pc_reg[IDX_W-1:0];
        buf_wr_data     = {half_reg[3:0], hv[3:0]};
        buf_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_axis_tuser)
                        CMD_SOF:
                        begin
                            column_next     = '0;
                            is_data_next    = 1'b0;
                            accum_next      = '0;
                            pc_next         = '0;
                            half_next       = '0;
                            run_open_next   = 1'b1;
                            fault_next      = 1'b0;
                            loaded_next     = 1'b0;
                            line_count_next = 16'd1;
                            halted_next     = 1'b0;
                        end
                        CMD_CHAR:
                        begin
                            if (!halted_reg)
                            begin
                                if (column_reg != COLUMN_MAX)
                                begin
                                    column_next = column_reg + 6'd1;
                                end
                                if (column_reg > BAR_COLUMN)
                                begin
                                    // ignore text past the bar
                                end
                                else if (column_reg == '0)
                                begin
                                    is_data_next = (s_axis_tdata == CH_ZERO);
                                    if (s_axis_tdata != CH_SPACE) fault_next = 1'b1;
                                end
                                else if (column_reg == 6'd1 && is_data_reg
                                         && s_axis_tdata == CH_X)
                                begin
                                    fault_next = 1'b0;
                                end
                                else if (column_reg == 6'd1 || !is_data_reg)
                                begin
                                    // comment record: spaces, then the bar
                                    is_data_next = 1'b0;
                                    if (column_reg < BAR_COLUMN)
                                    begin
                                        if (s_axis_tdata != CH_SPACE) fault_next = 1'b1;
                                    end
                                    else if (s_axis_tdata != CH_BAR)
                                    begin
                                        fault_next = 1'b1;
                                    end
                                end
                                else if (column_reg == BAR_COLUMN)
                                begin
                                    // a dangling nibble makes the line bad
                                    if (s_axis_tdata != CH_BAR || half_reg[4])
                                    begin
                                        fault_next = 1'b1;
                                    end
                                end
                                else if (column_reg < ADDR_COLUMN + 6'd3)
                                begin
                                    if (!is_hex) fault_next = 1'b1;
                                    accum_next = {accum_reg[7:0], hv[3:0]};
                                end
                                else if (column_reg == ADDR_COLUMN + 6'd3)
                                begin
                                    if (s_axis_tdata != CH_COLON) fault_next = 1'b1;
                                end
                                else if (column_reg < DATA_COLUMN)
                                begin
                                    if (s_axis_tdata != CH_SPACE) fault_next = 1'b1;
                                end
                                else if (run_open_reg && is_hex)
                                begin
                                    if (column_reg[0] == DATA_COLUMN[0])
                                    begin
                                        half_next = {1'b1, hv[3:0]};
                                    end
                                    else
                                    begin
                                        // second digit: store the byte
                                        buf_wr_en = (pc_reg < PC_MAX);
                                        if (pc_reg <= PC_MAX) pc_next = pc_reg + 1'b1;
                                        half_next = '0;
                                    end
                                end
                                else
                                begin
                                    // end of the pair run: only spaces allowed
                                    if (run_open_reg)
                                    begin
                                        run_open_next = 1'b0;
                                        if (column_reg[0] != DATA_COLUMN[0])
                                        begin
                                            half_next  = '0;
                                            fault_next = 1'b1;
                                        end
                                    end
                                    if (s_axis_tdata != CH_SPACE) fault_next = 1'b1;
                                end
                            end
                        end
                        CMD_EOL:
                        begin
                            if (!halted_reg)
                            begin
                                ln_next   = line_count_reg;
                                base_next = accum_reg;
                                cnt_next  = pc_reg;
                                idx_next  = '0;
                                if (eol_bad)
                                begin
                                    status_next = eol_data ? LS_BAD_DATA : LS_BAD_CMNT;
                                    halted_next = 1'b1;
                                    state_next  = ST_STATUS;
                                end
                                else
                                begin
                                    status_next = LS_OK;
                                    if (line_count_reg != 16'hFFFF)
                                    begin
                                        line_count_next = line_count_reg + 16'd1;
                                    end
                                    if (eol_data && pc_reg != '0)
                                    begin
                                        loaded_next    = 1'b1;
                                        last_addr_next = 12'(end_addr - 14'd1);
                                        state_next     = ST_READ;
                                    end
                                    else
                                    begin
                                        state_next = ST_STATUS;
                                    end
                                end
                                column_next   = '0;
                                is_data_next  = 1'b0;
                                accum_next    = '0;
                                pc_next       = '0;
                                half_next     = '0;
                                run_open_next = 1'b1;
                                fault_next    = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                buf_rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_we_next     = 1'b1;
                    out_addr_next   = base_reg + 12'(idx_reg);
                    out_data_next   = buf_rd_data;
                    out_status_next = LS_OK;
                    out_ln_next     = ln_reg;
                    out_last_next   = 1'b0;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = (idx_reg + 1'b1 == cnt_reg) ? ST_STATUS : ST_READ;
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_we_next     = 1'b0;
                    out_addr_next   = '0;
                    out_data_next   = '0;
                    out_status_next = status_reg;
                    out_ln_next     = ln_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            is_data_reg    <= 1'b0;
            accum_reg      <= '0;
            pc_reg         <= '0;
            half_reg       <= '0;
            run_open_reg   <= 1'b1;
            fault_reg      <= 1'b0;
            loaded_reg     <= 1'b0;
            line_count_reg <= 16'd1;
            halted_reg     <= 1'b0;
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg     <= column_next;
            is_data_reg    <= is_data_next;
            accum_reg      <= accum_next;
            pc_reg         <= pc_next;
            half_reg       <= half_next;
            run_open_reg   <= run_open_next;
            fault_reg      <= fault_next;
            loaded_reg     <= loaded_next;
            line_count_reg <= line_count_next;
            halted_reg     <= halted_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_addr_reg  <= last_addr_next;
        base_reg       <= base_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        ln_reg         <= ln_next;
        status_reg     <= status_next;
        out_we_reg     <= out_we_next;
        out_addr_reg   <= out_addr_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_ln_reg     <= out_ln_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_ln_reg, out_status_reg, out_data_reg, out_addr_reg};
    assign m_axis_tuser  = out_we_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> verif/load_record_checker.sv
module load_record_checker #(
    parameter int MAX_BYTES = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_char,
    input  wire logic [1:0]  in_cmd,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [39:0] out_data,
    input  wire logic        out_user,
    input  wire logic        out_last,
    output int               errors,
    output int               pending,
    output int               writes_seen,
    output int               statuses_seen,
    output int               rejects_seen
);
    import hrll_pkg::*;

    typedef struct packed {
        logic        we;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] line;
        logic        last;
    } load_result_t;

    load_result_t load_results_q[$];

    // Shadow of the loader state
    logic [5:0]  col;
    logic        data_line;
    logic [11:0] addr_acc;
    logic [4:0]  pairs;
    logic [4:0]  pend_nib;
    logic        run_open;
    logic        fault;
    logic [7:0]  bytes_q [0:MAX_BYTES-1];
    int          last_addr;
    logic [15:0] line_no;
    logic        halted;

    function automatic int digit_value(input logic [7:0] c);
        int d;
        d = 16;
        if (c >= "0" && c <= "9") d = c - "0";
        else if (c >= "a" && c <= "f") d = c - "a" + 10;
        else if (c >= "A" && c <= "F") d = c - "A" + 10;
        return d;
    endfunction

    function automatic void clear_line();
        col       = '0;
        data_line = 1'b0;
        addr_acc  = '0;
        pairs     = '0;
        pend_nib  = '0;
        run_open  = 1'b1;
        fault     = 1'b0;
    endfunction

    function automatic void restart_file();
        clear_line();
        last_addr = -1;
        line_no   = 16'd1;
        halted    = 1'b0;
    endfunction

    function automatic void queue_result(input logic we, input logic [11:0] a,
                                         input logic [7:0] d, input logic [1:0] st,
                                         input logic lst);
        load_result_t r;
        r.we     = we;
        r.addr   = a;
        r.data   = d;
        r.status = st;
        r.line   = line_no;
        r.last   = lst;
        load_results_q.push_back(r);
    endfunction

    function automatic void take_char(input logic [7:0] ch);
        logic [5:0] c;
        logic [5:0] offs;
        int         v;
        c = col;
        v = digit_value(ch);
        if (col < COLUMN_MAX) col = col + 6'd1;
        if (c > BAR_COLUMN) return;
        if (c == 6'd0) begin
            data_line = (ch == CH_ZERO);
            if (ch != CH_SPACE) fault = 1'b1;
            return;
        end
        if (c == 6'd1) begin
            if (data_line && ch == CH_X) begin
                fault = 1'b0;
                return;
            end
            data_line = 1'b0;
        end
        if (!data_line) begin
            if (c < BAR_COLUMN) begin
                if (ch != CH_SPACE) fault = 1'b1;
            end else if (ch != CH_BAR) begin
                fault = 1'b1;
            end
            return;
        end
        if (c == BAR_COLUMN) begin
            if (ch != CH_BAR || pend_nib[4]) fault = 1'b1;
            return;
        end
        if (c < ADDR_COLUMN + 6'd3) begin
            if (v > 15) fault = 1'b1;
            addr_acc = {addr_acc[7:0], 4'(v)};
            return;
        end
        if (c == ADDR_COLUMN + 6'd3) begin
            if (ch != CH_COLON) fault = 1'b1;
            return;
        end
        if (c < DATA_COLUMN) begin
            if (ch != CH_SPACE) fault = 1'b1;
            return;
        end
        if (run_open) begin
            offs = c - DATA_COLUMN;
            if (!offs[0]) begin
                if (v <= 15) begin
                    pend_nib = {1'b1, 4'(v)};
                    return;
                end
                run_open = 1'b0;
            end else begin
                if (v <= 15) begin
                    if (pairs < MAX_BYTES) bytes_q[pairs] = {pend_nib[3:0], 4'(v)};
                    if (pairs <= MAX_BYTES) pairs = pairs + 5'd1;
                    pend_nib = '0;
                    return;
                end
                run_open = 1'b0;
                pend_nib = '0;
                fault    = 1'b1;
            end
        end
        if (ch != CH_SPACE) fault = 1'b1;
    endfunction

    function automatic void close_line();
        logic is_data;
        logic bad;
        int   i;
        is_data = data_line && (col >= ADDR_COLUMN);
        bad     = fault || (col <= BAR_COLUMN);
        if (is_data && !bad) begin
            if (int'(addr_acc) <= last_addr) bad = 1'b1;
            if (pairs > MAX_BYTES || int'(addr_acc) + int'(pairs) > MEM_SIZE) bad = 1'b1;
        end
        if (bad) begin
            queue_result(1'b0, '0, '0, is_data ? LS_BAD_DATA : LS_BAD_CMNT, 1'b1);
            halted = 1'b1;
        end else begin
            if (is_data) begin
                for (i = 0; i < pairs && i < MAX_BYTES; i++)
                    queue_result(1'b1, addr_acc + 12'(i), bytes_q[i], LS_OK, 1'b0);
                if (pairs > 0) last_addr = int'(addr_acc) + int'(pairs) - 1;
            end
            queue_result(1'b0, '0, '0, LS_OK, 1'b1);
            if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
        end
        clear_line();
    endfunction

    function automatic void apply_request(input logic [1:0] cmd, input logic [7:0] ch);
        case (cmd)
            CMD_SOF:  restart_file();
            CMD_CHAR: if (!halted) take_char(ch);
            CMD_EOL:  if (!halted) close_line();
            default:  ;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got, input logic [15:0] line);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch (line %0d): expected %0h, actual %0h",
                     $time, name, line, want, got);
        end
    endtask

    always @(posedge clk) begin
        load_result_t want;
        if (!rst_n) begin
            restart_file();
            load_results_q.delete();
            errors        = 0;
            writes_seen   = 0;
            statuses_seen = 0;
            rejects_seen  = 0;
        end else begin
            // retire the result before predicting the new request
            if (out_valid && out_ready) begin
                if (out_user) writes_seen++;
                if (out_last) statuses_seen++;
                if (out_last && out_data[21:20] != LS_OK) rejects_seen++;
                if (load_results_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual tuser=%0b tdata=%h tlast=%0b",
                             $time, out_user, out_data, out_last);
                end else begin
                    want = load_results_q.pop_front();
                    check_field("write_en", 16'(want.we), 16'(out_user), want.line);
                    check_field("addr", 16'(want.addr), 16'(out_data[11:0]), want.line);
                    check_field("data", 16'(want.data), 16'(out_data[19:12]), want.line);
                    check_field("line_status", 16'(want.status), 16'(out_data[21:20]),
                                want.line);
                    check_field("line_number", want.line, out_data[37:22], want.line);
                    check_field("tdata pad", 16'd0, 16'(out_data[39:38]), want.line);
                    check_field("last", 16'(want.last), 16'(out_last), want.line);
                end
            end
            if (in_valid && in_ready) apply_request(in_cmd, in_char);
        end
        pending = load_results_q.size();
    end

endmodule

>>> verif/hex_record_line_loader_test.sv
module hex_record_line_loader_test;
    import hrll_pkg::*;

    localparam int         MAX_BYTES    = 10;
    localparam int         RANDOM_ITEMS = 320;
    // no idling on either side for this many requests at the end
    localparam int         QUIET_ITEMS  = 60;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    typedef enum int {
        LN_DATA_OK,
        LN_DATA_EMPTY,
        LN_CMNT_OK,
        LN_CMNT_BAD,
        LN_BAD_ADDR_DIGIT,
        LN_BAD_COLON,
        LN_BAD_GAP,
        LN_ODD_DIGIT,
        LN_STALE_ADDR,
        LN_MEM_OVERFLOW,
        LN_BAD_PAD,
        LN_NO_BAR,
        LN_WRONG_BAR
    } line_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic [1:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;
    logic        m_user;
    logic        m_last;

    int errors;
    int pending;
    int writes_seen;
    int statuses_seen;
    int rejects_seen;

    // stimulus bookkeeping
    logic [7:0] line_q[$];
    int         file_last;
    int         items_sent;
    int         lines_sent;
    int         files_sent;
    int         directed_end;
    bit         gaps_on   = 1'b1;
    bit         stalls_on = 1'b1;
    bit         halted_guess;
    bit         pressure_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hex_record_line_loader #(
        .MAX_BYTES(MAX_BYTES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // ch[7:0]
        .s_axis_tuser  (s_user),    // cmd[1:0]
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),    // addr[11:0], data[19:12], line_status[21:20],
                                    // line_number[37:22], zero pad
        .m_axis_tuser  (m_user),    // write_en
        .m_axis_tlast  (m_last)     // last
    );

    load_record_checker #(
        .MAX_BYTES(MAX_BYTES)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_char       (s_data),
        .in_cmd        (s_user),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_data      (m_data),
        .out_user      (m_user),
        .out_last      (m_last),
        .errors        (errors),
        .pending       (pending),
        .writes_seen   (writes_seen),
        .statuses_seen (statuses_seen),
        .rejects_seen  (rejects_seen)
    );

    // Hard stop in case a handshake never completes
    initial
    begin
        #5_000_000;
        $display("** hex_record_line_loader: FAILED **");
        $finish;
    end

    // Receiver: drop tready in random bursts, update at the
    // falling edge so the block samples a settled value.
    initial
    begin
        m_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 6) == 0)
            begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                m_ready = 1'b1;
            end
        end
    end

    // Present one request, wait for it to be taken, return at the next
    // falling edge with tvalid still high. Callers that pause lower tvalid.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap     = $urandom_range(1, 16);
            s_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid = 1'b1;
        s_data  = ch;
        s_user  = cmd;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Push the buffered line character by character, then close it.
    task automatic send_line();
        foreach (line_q[i]) send_request(CMD_CHAR, line_q[i]);
        send_request(CMD_EOL, 8'h00);
        lines_sent++;
    endtask

    task automatic new_file();
        send_request(CMD_SOF, 8'($urandom_range(0, 255)));
        file_last    = -1;
        halted_guess = 1'b0;
        files_sent++;
    endtask

    // Hex digit in random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10) return "0" + {4'd0, n};
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + {4'd0, n} - 8'd10;
    endfunction

    // Neither hex, space, colon nor bar
    function automatic logic [7:0] stray_char();
        case ($urandom_range(0, 5))
            0:       return "g";
            1:       return "G";
            2:       return "/";
            3:       return "@";
            4:       return "~";
            default: return ".";
        endcase
    endfunction

    // Append random text past the bar, now and then long enough to saturate
    // the column counter.
    task automatic add_tail();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 45)) line_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_comment_line(input bit bad);
        int cut;
        line_q.delete();
        repeat (int'(BAR_COLUMN)) line_q.push_back(CH_SPACE);
        line_q.push_back(CH_BAR);
        add_tail();
        if (bad)
        begin
            case ($urandom_range(0, 3))
                0: line_q[$urandom_range(0, int'(BAR_COLUMN) - 1)] =
                       8'($urandom_range(33, 255));
                1:
                begin
                    // starts like a data record but the second character is not x
                    line_q[0] = CH_ZERO;
                    line_q[1] = stray_char();
                end
                2:
                begin
                    // short line, down to an empty one
                    cut = $urandom_range(0, int'(BAR_COLUMN));
                    while (line_q.size() > cut) void'(line_q.pop_back());
                end
                default: line_q[BAR_COLUMN] = stray_char();
            endcase
        end
    endtask

    task automatic build_data_line(input line_kind_t kind);
        int          n;
        int          addr;
        int          lo;
        int          hi;
        int          k;
        int          cut;
        logic [11:0] a;
        logic [7:0]  b;
        line_q.delete();
        n = (kind == LN_DATA_EMPTY) ? 0 : $urandom_range(1, MAX_BYTES);
        if (n != 0 && $urandom_range(0, 3) == 0) n = MAX_BYTES;
        lo = file_last + 1;
        hi = (MEM_SIZE - n > MEM_SIZE - 1) ? MEM_SIZE - 1 : MEM_SIZE - n;
        case (kind)
            LN_STALE_ADDR: addr = $urandom_range(0, 1) ? file_last : $urandom_range(0, file_last);
            LN_MEM_OVERFLOW:
            begin
                if (n < 2) n = 2;
                addr = MEM_SIZE - n + $urandom_range(1, n - 1);
            end
            default:
            begin
                // mostly small steps, sometimes an exact fit at the top of memory
                if ($urandom_range(0, 5) == 0) addr = hi;
                else addr = lo + $urandom_range(0, (hi - lo < 700) ? hi - lo : 700);
            end
        endcase
        a = addr[11:0];
        line_q.push_back(CH_ZERO);
        line_q.push_back(CH_X);
        line_q.push_back(hex_char(a[11:8]));
        line_q.push_back(hex_char(a[7:4]));
        line_q.push_back(hex_char(a[3:0]));
        if (kind == LN_BAD_ADDR_DIGIT) line_q[$urandom_range(2, 4)] = stray_char();
        line_q.push_back((kind == LN_BAD_COLON) ? stray_char() : CH_COLON);
        line_q.push_back((kind == LN_BAD_GAP) ? stray_char() : CH_SPACE);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            line_q.push_back(hex_char(b[7:4]));
            line_q.push_back(hex_char(b[3:0]));
        end
        if (kind == LN_ODD_DIGIT) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
        while (line_q.size() < int'(BAR_COLUMN)) line_q.push_back(CH_SPACE);
        if (kind == LN_BAD_PAD)
            line_q[$urandom_range(int'(DATA_COLUMN) + 2 * n, int'(BAR_COLUMN) - 1)] =
                stray_char();
        line_q.push_back((kind == LN_WRONG_BAR) ? stray_char() : CH_BAR);
        add_tail();
        if (kind == LN_NO_BAR)
        begin
            cut = $urandom_range(2, int'(BAR_COLUMN));
            while (line_q.size() > cut) void'(line_q.pop_back());
        end
        if ((kind == LN_DATA_OK || kind == LN_DATA_EMPTY) && n > 0) file_last = addr + n - 1;
    endtask

    initial
    begin
        line_kind_t kind;
        int         pick;
        rst_n         = 1'b0;
        s_valid       = 1'b0;
        s_data        = 8'h00;
        s_user        = CMD_CHAR;
        items_sent    = 0;
        lines_sent    = 0;
        files_sent    = 0;
        file_last     = -1;
        halted_guess  = 1'b0;
        pressure_done = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: start of file, reserved command, empty line, requests
        // ignored while halted, and the short records.
        send_request(CMD_SOF, 8'h00);
        send_request(CMD_NONE, 8'hFF);
        send_request(CMD_EOL, 8'h00);
        send_request(CMD_CHAR, "A");
        send_request(CMD_EOL, 8'h00);
        send_request(CMD_SOF, 8'h00);
        send_request(CMD_CHAR, "0");
        send_request(CMD_EOL, 8'h00);
        send_request(CMD_SOF, 8'h00);
        send_request(CMD_CHAR, "0");
        send_request(CMD_CHAR, "x");
        send_request(CMD_EOL, 8'h00);
        send_request(CMD_SOF, 8'h00);
        send_request(CMD_CHAR, " ");
        send_request(CMD_CHAR, "Z");
        send_request(CMD_EOL, 8'h00);
        send_request(CMD_SOF, 8'h00);
        send_request(CMD_CHAR, "0");
        send_request(CMD_CHAR, "x");
        send_request(CMD_CHAR, "f");
        send_request(CMD_CHAR, "F");
        send_request(CMD_CHAR, "a");
        send_request(CMD_EOL, 8'h00);
        halted_guess = 1'b1;
        directed_end = items_sent;

        // Random: mostly well-formed files, with bad records mixed in. A bad
        // record halts the loader, so restart the file after one.
        while (items_sent < directed_end + RANDOM_ITEMS)
        begin
            if (items_sent >= directed_end + RANDOM_ITEMS - QUIET_ITEMS)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            // hold off once until every pending result has drained
            if (!pressure_done && items_sent >= directed_end + RANDOM_ITEMS / 2)
            begin
                s_valid = 1'b0;
                wait (pending == 0);
                @(negedge clk);
                pressure_done = 1'b1;
            end
            if (halted_guess || file_last >= MEM_SIZE - 1 - MAX_BYTES) new_file();
            pick = $urandom_range(0, 99);
            if (pick < 45) kind = LN_DATA_OK;
            else if (pick < 52) kind = LN_DATA_EMPTY;
            else if (pick < 64) kind = LN_CMNT_OK;
            else if (pick < 68) kind = LN_CMNT_BAD;
            else kind = line_kind_t'($urandom_range(int'(LN_BAD_ADDR_DIGIT), int'(LN_WRONG_BAR)));
            if (kind == LN_STALE_ADDR && file_last < 0) kind = LN_MEM_OVERFLOW;
            if (kind == LN_CMNT_OK || kind == LN_CMNT_BAD) build_comment_line(kind == LN_CMNT_BAD);
            else build_data_line(kind);
            send_line();
            if (kind != LN_DATA_OK && kind != LN_DATA_EMPTY && kind != LN_CMNT_OK)
            begin
                halted_guess = 1'b1;
                // advance a little junk through the halted loader
                if ($urandom_range(0, 2) == 0)
                begin
                    line_q.delete();
                    repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(0, 255)));
                    send_line();
                end
            end
        end

        // Drain: drop tvalid, wait out every expected result, then idle a bit
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge clk);

        $display("Run covered %0d requests: %0d random lines in %0d files.",
                 items_sent, lines_sent, files_sent);
        $display("Checked %0d byte writes and %0d line statuses, %0d of them rejections.",
                 writes_seen, statuses_seen, rejects_seen);
        if (errors == 0 && pending == 0)
            $display("** hex_record_line_loader: PASSED **");
        else
            $display("** hex_record_line_loader: FAILED **");
        $finish;
    end

endmodule
